FILE: hdl/xrsh_pkg.sv
package xrsh_pkg;

  localparam int Iterations = 1;

  localparam int WordWidth  = 64;
  localparam int HalfWidth  = 32;
  localparam int ShiftWidth = 6;
  localparam int KindWidth  = 2;
  localparam int IndexWidth = 2;

  localparam logic [KindWidth-1:0] KIND_SEED   = 2'd0;
  localparam logic [KindWidth-1:0] KIND_DRAW64 = 2'd1;
  localparam logic [KindWidth-1:0] KIND_DRAW32 = 2'd2;

  localparam logic [IndexWidth-1:0] REG_ROTATE_A = 2'd0;
  localparam logic [IndexWidth-1:0] REG_SHIFT_B  = 2'd1;
  localparam logic [IndexWidth-1:0] REG_ROTATE_C = 2'd2;

  localparam logic [ShiftWidth-1:0] ROTATE_A_RESET = 6'd24;
  localparam logic [ShiftWidth-1:0] SHIFT_B_RESET  = 6'd16;
  localparam logic [ShiftWidth-1:0] ROTATE_C_RESET = 6'd37;

  typedef logic [WordWidth-1:0] word_t;

  typedef struct packed {
    logic [ShiftWidth-1:0] rotate_a;
    logic [ShiftWidth-1:0] shift_b;
    logic [ShiftWidth-1:0] rotate_c;
  } cfg_t;

  function automatic word_t rotl(input word_t x, input logic [ShiftWidth-1:0] k);
    logic [2*WordWidth-1:0] both;
    both = {x, x} << k;
    return both[2*WordWidth-1:WordWidth];
  endfunction

endpackage

FILE: hdl/xrsh_cfg.sv
module xrsh_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [xrsh_pkg::IndexWidth-1:0] cfg_index,
  input  logic [xrsh_pkg::ShiftWidth-1:0] cfg_data,
  output xrsh_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotate_a <= xrsh_pkg::ROTATE_A_RESET;
      cfg.shift_b  <= xrsh_pkg::SHIFT_B_RESET;
      cfg.rotate_c <= xrsh_pkg::ROTATE_C_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        xrsh_pkg::REG_ROTATE_A: cfg.rotate_a <= cfg_data;
        xrsh_pkg::REG_SHIFT_B:  cfg.shift_b  <= cfg_data;
        xrsh_pkg::REG_ROTATE_C: cfg.rotate_c <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/xrsh_step.sv
module xrsh_step (
  input  xrsh_pkg::cfg_t  cfg,
  input  xrsh_pkg::word_t first_in,
  input  xrsh_pkg::word_t second_in,
  output xrsh_pkg::word_t first_out,
  output xrsh_pkg::word_t second_out,
  output xrsh_pkg::word_t sum
);

  xrsh_pkg::word_t first_s  [xrsh_pkg::Iterations+1];
  xrsh_pkg::word_t second_s [xrsh_pkg::Iterations+1];
  xrsh_pkg::word_t mix_s    [xrsh_pkg::Iterations];

  assign first_s[0]  = first_in;
  assign second_s[0] = second_in;

  for (genvar i = 0; i < xrsh_pkg::Iterations; i++) begin : g_adv
    assign mix_s[i]      = first_s[i] ^ second_s[i];
    assign first_s[i+1]  = xrsh_pkg::rotl(first_s[i], cfg.rotate_a) ^ mix_s[i]
                           ^ (mix_s[i] << cfg.shift_b);
    assign second_s[i+1] = xrsh_pkg::rotl(mix_s[i], cfg.rotate_c);
  end

  // value of the last advance, taken before it
  assign sum        = first_s[xrsh_pkg::Iterations-1] + second_s[xrsh_pkg::Iterations-1];
  assign first_out  = first_s[xrsh_pkg::Iterations];
  assign second_out = second_s[xrsh_pkg::Iterations];

endmodule

FILE: hdl/xoroshiro128_plus_generator_unit.sv
// channel | direction | handshake          | payload
// input   | in        | in_valid, in_stall | kind, seed_first, seed_second
// output  | out       | out_valid, out_stall | random_value
// config  | in        | cfg_write          | cfg_index, cfg_data
//
// one word per cycle sustained while the result register is free; a result passes
// through the input register and then the result register
// the state update (xor, rotate, shift) runs from the state registers back into them,
// and one 64-bit add of the state words feeds the result register
// rst clears both state words, the held sum, the half phase and both stages
// while a result waits under out_stall one more input word is still taken
module xoroshiro128_plus_generator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [xrsh_pkg::KindWidth-1:0]  kind,
  input  logic [xrsh_pkg::WordWidth-1:0]  seed_first,
  input  logic [xrsh_pkg::WordWidth-1:0]  seed_second,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [xrsh_pkg::WordWidth-1:0]  random_value,
  input  logic                            cfg_write,
  input  logic [xrsh_pkg::IndexWidth-1:0] cfg_index,
  input  logic [xrsh_pkg::ShiftWidth-1:0] cfg_data
);

  xrsh_pkg::cfg_t cfg;

  logic                           s1_valid;
  logic [xrsh_pkg::KindWidth-1:0] s1_kind;
  xrsh_pkg::word_t                s1_seed_first;
  xrsh_pkg::word_t                s1_seed_second;

  xrsh_pkg::word_t word_first;
  xrsh_pkg::word_t word_second;
  xrsh_pkg::word_t held_sum;
  logic            half_phase;

  xrsh_pkg::word_t first_adv;
  xrsh_pkg::word_t second_adv;
  xrsh_pkg::word_t sum;

  logic s1_has_result;
  logic s1_go;
  logic accept;

  xrsh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  xrsh_step u_step (
    .cfg        (cfg),
    .first_in   (word_first),
    .second_in  (word_second),
    .first_out  (first_adv),
    .second_out (second_adv),
    .sum        (sum)
  );

  assign s1_has_result = (s1_kind == xrsh_pkg::KIND_DRAW64) ||
                         (s1_kind == xrsh_pkg::KIND_DRAW32);
  assign s1_go    = s1_valid && (!s1_has_result || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind        <= kind;
      s1_seed_first  <= seed_first;
      s1_seed_second <= seed_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_first  <= '0;
      word_second <= '0;
      held_sum    <= '0;
      half_phase  <= 1'b0;
    end else if (s1_go) begin
      case (s1_kind)
        xrsh_pkg::KIND_SEED: begin
          word_first  <= s1_seed_first;
          word_second <= s1_seed_second;
          half_phase  <= 1'b0;
        end
        xrsh_pkg::KIND_DRAW64: begin
          word_first  <= first_adv;
          word_second <= second_adv;
        end
        xrsh_pkg::KIND_DRAW32: begin
          if (!half_phase) begin
            word_first  <= first_adv;
            word_second <= second_adv;
            held_sum    <= sum;
          end
          half_phase <= !half_phase;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_has_result) begin
      if (s1_kind == xrsh_pkg::KIND_DRAW64) begin
        random_value <= sum;
      end else if (!half_phase) begin
        random_value <= {{xrsh_pkg::HalfWidth{1'b0}}, sum[xrsh_pkg::HalfWidth-1:0]};
      end else begin
        random_value <= {{xrsh_pkg::HalfWidth{1'b0}},
                         held_sum[xrsh_pkg::WordWidth-1:xrsh_pkg::HalfWidth]};
      end
    end
  end

endmodule
